[rtl/core/dtdpf_pkg.sv]
// Shared types and constants for the duplicate packet filter core.
// Depends on nothing; imported by every module of the core.
package dtdpf_pkg;

  // Parameter defaults
  localparam int TABLE_ENTRIES_DEF    = 1024;
  localparam int MAX_PACKET_BYTES_DEF = 65535;

  // Result queue depth, also the limit on packets in flight
  localparam int OUTQ_DEPTH = 16;

  // One input beat: a packet byte, end-of-packet mark and time stamp
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] current_time;
  } pkt_beat_t;

  // One result beat
  typedef struct packed {
    logic [31:0] age_seconds;
    logic [31:0] packet_hash;
    logic        too_long;
  } res_beat_t;

  // Per-packet lookup context carried down the pipeline
  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] stamp;
    logic        too_long;
  } lookup_t;

  // One table entry; a zero stamp marks an empty slot
  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] stamp;
  } entry_t;

endpackage

[rtl/core/dual_table_duplicate_packet_filter_core.sv]
// Top level of the duplicate packet filter: hash fold, index pipeline, two
// tables and the result queue. Depends on dtdpf_pkg and all dtdpf_* modules.
//
//   channel | direction | handshake            | payload
//   pkt     | in        | pkt_valid, pkt_ready | pkt_beat_t (one packet byte)
//   res     | out       | res_valid, res_ready | res_beat_t (one per packet)
//
// One byte beat per cycle while pkt_ready is high; a packet's result
// passes hash, index, tables and queue; the next packet hashes meanwhile.
// After reset both tables take a clearing pass over all TABLE_ENTRIES
// slots with pkt_ready low.
// Up to OUTQ_DEPTH packets may be between their final byte and the result
// taken; beyond that pkt_ready drops until res_ready drains the queue.
module dual_table_duplicate_packet_filter_core #(
  parameter int TABLE_ENTRIES    = dtdpf_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_PACKET_BYTES = dtdpf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pkt_valid,
  output logic                 pkt_ready,
  input  dtdpf_pkg::pkt_beat_t pkt,
  output logic                 res_valid,
  input  logic                 res_ready,
  output dtdpf_pkg::res_beat_t res
);
  import dtdpf_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int Q_W   = $clog2(OUTQ_DEPTH);

  logic             accept;
  logic             pop;
  logic             hash_valid;
  lookup_t          hash_meta;
  logic             idx_valid;
  lookup_t          idx_meta;
  logic [IDX_W-1:0] left_idx;
  logic [IDX_W-1:0] right_idx;
  logic             left_busy;
  logic             right_busy;
  logic             left_age_valid;
  logic             right_age_valid;
  logic [31:0]      left_age;
  logic [31:0]      right_age;
  lookup_t          meta_r;
  lookup_t          meta_a;
  res_beat_t        push_beat;

  res_beat_t        q_mem [OUTQ_DEPTH];
  logic [Q_W:0]     wr_ptr;
  logic [Q_W:0]     rd_ptr;
  logic [Q_W:0]     occ;

  // Handshakes; occ counts packets from final byte until result taken
  assign accept    = pkt_valid & pkt_ready;
  assign pop       = res_valid & res_ready;
  assign pkt_ready = ~left_busy & ~right_busy & (occ < (Q_W + 1)'(OUTQ_DEPTH));

  dtdpf_hash #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_hash (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .beat      (pkt),
    .hash_valid(hash_valid),
    .hash_meta (hash_meta)
  );

  dtdpf_index #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_index (
    .clk      (clk),
    .rst      (rst),
    .in_valid (hash_valid),
    .in_meta  (hash_meta),
    .out_valid(idx_valid),
    .out_meta (idx_meta),
    .left_idx (left_idx),
    .right_idx(right_idx)
  );

  dtdpf_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_left (
    .clk      (clk),
    .rst      (rst),
    .busy     (left_busy),
    .rd_valid (idx_valid),
    .rd_idx   (left_idx),
    .hash     (idx_meta.hash),
    .stamp    (idx_meta.stamp),
    .age_valid(left_age_valid),
    .age      (left_age)
  );

  dtdpf_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_right (
    .clk      (clk),
    .rst      (rst),
    .busy     (right_busy),
    .rd_valid (idx_valid),
    .rd_idx   (right_idx),
    .hash     (idx_meta.hash),
    .stamp    (idx_meta.stamp),
    .age_valid(right_age_valid),
    .age      (right_age)
  );

  // Context follows the two table stages
  always_ff @(posedge clk) begin
    meta_r <= idx_meta;
    meta_a <= meta_r;
  end

  // Lesser nonzero age of the two tables
  always_comb begin
    if (left_age == 32'd0) begin
      push_beat.age_seconds = right_age;
    end else if (right_age == 32'd0) begin
      push_beat.age_seconds = left_age;
    end else begin
      push_beat.age_seconds = (left_age > right_age) ? right_age : left_age;
    end
    push_beat.packet_hash = meta_a.hash;
    push_beat.too_long    = meta_a.too_long;
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (left_age_valid && right_age_valid) begin
      q_mem[wr_ptr[Q_W-1:0]] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (left_age_valid && right_age_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      occ <= occ + (Q_W + 1)'(accept & pkt.last_byte) - (Q_W + 1)'(pop);
    end
  end

  assign res_valid = (wr_ptr != rd_ptr);
  assign res       = q_mem[rd_ptr[Q_W-1:0]];

endmodule

[rtl/core/dtdpf_hash.sv]
// Byte-serial hash fold and end-of-packet finish (rotate, XOR, absolute value).
// Depends on dtdpf_pkg.
module dtdpf_hash #(
  parameter int MAX_PACKET_BYTES = dtdpf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  dtdpf_pkg::pkt_beat_t beat,
  output logic                 hash_valid,
  output dtdpf_pkg::lookup_t   hash_meta
);
  import dtdpf_pkg::*;

  localparam logic [15:0] MAX_BYTES = 16'(MAX_PACKET_BYTES);

  // Running fold state
  logic [31:0] acc;
  logic [23:0] gather;
  logic [15:0] count;
  logic        ovf;

  logic [31:0] acc_next;
  logic [23:0] gather_next;
  logic [15:0] count_next;
  logic        ovf_next;
  logic        room;
  logic [1:0]  pos;

  // Finish stage one
  logic        f_valid;
  logic [31:0] f_acc;
  logic [31:0] f_init;
  logic [4:0]  f_words;
  logic        f_too_long;
  logic [31:0] f_stamp;

  logic [63:0] rot_wide;
  logic [31:0] h_raw;
  logic [31:0] h_abs;

  // Fold one byte
  always_comb begin
    room        = count < MAX_BYTES;
    pos         = count[1:0];
    acc_next    = acc;
    gather_next = gather;
    count_next  = count;
    ovf_next    = ovf | ~room;
    if (room) begin
      count_next = count + 16'd1;
      if (pos == 2'd3) begin
        acc_next    = {acc[30:0], acc[31]} ^ {beat.data_byte, gather};
        gather_next = '0;
      end else begin
        gather_next = gather | (24'(beat.data_byte) << {pos, 3'b000});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      gather  <= '0;
      count   <= '0;
      ovf     <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept & beat.last_byte;
      if (accept) begin
        if (beat.last_byte) begin
          acc    <= '0;
          gather <= '0;
          count  <= '0;
          ovf    <= 1'b0;
        end else begin
          acc    <= acc_next;
          gather <= gather_next;
          count  <= count_next;
          ovf    <= ovf_next;
        end
      end
    end
  end

  // Capture the tail for the finish
  always_ff @(posedge clk) begin
    if (accept && beat.last_byte) begin
      f_acc      <= acc_next;
      f_init     <= {8'd0, gather_next} + {13'd0, count_next, 3'b000};
      f_words    <= count_next[6:2];
      f_too_long <= ovf_next;
      f_stamp    <= beat.current_time;
    end
  end

  // Rotate tail in by word count, then absolute value
  always_comb begin
    rot_wide = {f_init, f_init} << f_words;
    h_raw    = f_acc ^ rot_wide[63:32];
    h_abs    = h_raw[31] ? (32'd0 - h_raw) : h_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else begin
      hash_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    hash_meta.hash     <= h_abs;
    hash_meta.stamp    <= f_stamp;
    hash_meta.too_long <= f_too_long;
  end

endmodule

[rtl/core/dtdpf_index.sv]
// Table index pipeline: takes both 16-bit hash slices modulo the table size
// by reciprocal multiply and one correction. Depends on dtdpf_pkg.
module dtdpf_index #(
  parameter int  TABLE_ENTRIES = dtdpf_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  dtdpf_pkg::lookup_t in_meta,
  output logic               out_valid,
  output dtdpf_pkg::lookup_t out_meta,
  output logic [IDX_W-1:0]   left_idx,
  output logic [IDX_W-1:0]   right_idx
);
  import dtdpf_pkg::*;

  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / TABLE_ENTRIES);
  localparam logic [16:0] DIVISOR = 17'(TABLE_ENTRIES);

  logic [1:0][15:0] slice;
  logic [1:0][47:0] prod;

  // Stage one: quotient estimate
  logic             v1;
  lookup_t          meta1;
  logic [1:0][15:0] x1;
  logic [1:0][15:0] q1;

  // Stage two: remainder below twice the divisor
  logic             v2;
  lookup_t          meta2;
  logic [1:0][32:0] qn;
  logic [1:0][16:0] r2;

  logic [1:0][16:0] r3;

  // Left and right slices of the hash
  always_comb begin
    slice[0] = {in_meta.hash[31:24], in_meta.hash[15:8]};
    slice[1] = {in_meta.hash[23:16], in_meta.hash[7:0]};
    for (int s = 0; s < 2; s++) begin
      prod[s] = 48'(slice[s]) * 48'(RECIP);
    end
  end

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      qn[s] = 33'(q1[s]) * 33'(DIVISOR);
    end
  end

  // Single correction step
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      r3[s] = (r2[s] >= DIVISOR) ? (r2[s] - DIVISOR) : r2[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    meta1 <= in_meta;
    meta2 <= meta1;
    out_meta <= meta2;
    for (int s = 0; s < 2; s++) begin
      x1[s] <= slice[s];
      q1[s] <= prod[s][47:32];
      r2[s] <= {1'b0, x1[s]} - qn[s][16:0];
    end
    left_idx  <= r3[0][IDX_W-1:0];
    right_idx <= r3[1][IDX_W-1:0];
  end

endmodule

[rtl/core/dtdpf_table.sv]
// One hash/time table in a synchronous RAM: read, age compare, write back,
// with forwarding for back-to-back reads of one slot and a clearing pass after reset.
// Depends on dtdpf_pkg.
module dtdpf_table #(
  parameter int  TABLE_ENTRIES = dtdpf_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  output logic             busy,
  input  logic             rd_valid,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic [31:0]      hash,
  input  logic [31:0]      stamp,
  output logic             age_valid,
  output logic [31:0]      age
);
  import dtdpf_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  entry_t mem [TABLE_ENTRIES];

  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  // Read-return stage
  logic             r_valid;
  logic [IDX_W-1:0] r_idx;
  logic [31:0]      r_hash;
  logic [31:0]      r_stamp;
  entry_t           rd_data;
  logic             byp;
  entry_t           byp_data;

  entry_t           cur;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;
  logic [31:0]      diff;
  logic [31:0]      age_next;

  assign busy = clearing;

  // Write port: clearing pass or write-back
  always_comb begin
    we = clearing | r_valid;
    wa = clearing ? clr_idx : r_idx;
    wd = '0;
    if (!clearing) begin
      wd.hash  = r_hash;
      wd.stamp = r_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_valid) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Entry as seen by this packet, then its age
  always_comb begin
    cur  = byp ? byp_data : rd_data;
    diff = r_stamp - cur.stamp;
    if (cur.hash == r_hash && cur.stamp != 32'd0) begin
      age_next = (diff == 32'd0) ? 32'd1 : diff;
    end else begin
      age_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      r_valid   <= 1'b0;
      age_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == LAST_IDX) begin
          clearing <= 1'b0;
        end
      end
      r_valid   <= rd_valid;
      age_valid <= r_valid;
    end
  end

  // Forward the entry being written when the next packet reads it
  always_ff @(posedge clk) begin
    r_idx    <= rd_idx;
    r_hash   <= hash;
    r_stamp  <= stamp;
    byp      <= r_valid && (rd_idx == r_idx);
    byp_data <= wd;
    age      <= age_next;
  end

endmodule

[verif/tb.sv]
// Self-checking testbench for dual_table_duplicate_packet_filter_core.
// Needs dtdpf_pkg and the core RTL. Packet bytes go in through a typed table,
// then random traffic with repeats and a flood; typed rows are checked
// against those answers, others against a built-in hash and table predictor.
module tb;
  import dtdpf_pkg::*;

  localparam int unsigned TABLE_SIZE   = TABLE_ENTRIES_DEF;
  localparam int unsigned MAX_BYTES    = MAX_PACKET_BYTES_DEF;
  localparam int unsigned BUF_LEN      = 80;
  localparam int unsigned SAVED_SLOTS  = 32;
  localparam int unsigned RANDOM_BEATS = 1650;
  localparam int unsigned FLOOD_START  = 600;
  localparam int unsigned FLOOD_COUNT  = 40;
  localparam int unsigned HOLD_CYCLES  = 400;

  // Directed stimulus: one beat per row, expected result on final-byte rows
  typedef struct packed {
    pkt_beat_t beat;
    res_beat_t want;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 24;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // one zero byte: new, then aged, same second, and time going backwards
    '{'{8'h00, 1'b1, 32'd1},          '{32'd0, 32'h0000_0008, 1'b0}},
    '{'{8'h00, 1'b1, 32'd5},          '{32'd4, 32'h0000_0008, 1'b0}},
    '{'{8'h00, 1'b1, 32'd5},          '{32'd1, 32'h0000_0008, 1'b0}},
    '{'{8'h00, 1'b1, 32'd3},          '{32'hFFFF_FFFE, 32'h0000_0008, 1'b0}},
    // stored at time zero, so the repeat still reads as new
    '{'{8'hFF, 1'b1, 32'd0},          '{32'd0, 32'h0000_0107, 1'b0}},
    '{'{8'hFF, 1'b1, 32'd7},          '{32'd0, 32'h0000_0107, 1'b0}},
    // one all-ones word: negative fold, absolute value taken
    '{'{8'hFF, 1'b0, 32'h0000_0000}, '0},
    '{'{8'hFF, 1'b0, 32'hFFFF_FFFF}, '0},
    '{'{8'hFF, 1'b0, 32'h0000_0000}, '0},
    '{'{8'hFF, 1'b1, 32'hFFFF_FFFF}, '{32'd0, 32'h0000_0041, 1'b0}},
    // two tail bytes, no full word
    '{'{8'h12, 1'b0, 32'hAAAA_AAAA}, '0},
    '{'{8'h34, 1'b1, 32'h8000_0000}, '{32'd0, 32'h0000_3422, 1'b0}},
    // fold lands on the most negative value, which stays as it is
    '{'{8'h40, 1'b0, 32'h0000_0000}, '0},
    '{'{8'h00, 1'b0, 32'h0000_0000}, '0},
    '{'{8'h00, 1'b0, 32'h0000_0000}, '0},
    '{'{8'h80, 1'b1, 32'h1234_5678}, '{32'd0, 32'h8000_0000, 1'b0}},
    // fold cancels to a zero hash, then seen again
    '{'{8'h40, 1'b0, 32'h5555_5555}, '0},
    '{'{8'h00, 1'b0, 32'h0000_0000}, '0},
    '{'{8'h00, 1'b0, 32'h0000_0000}, '0},
    '{'{8'h00, 1'b1, 32'd9},          '{32'd0, 32'h0000_0000, 1'b0}},
    '{'{8'h40, 1'b0, 32'h0000_0000}, '0},
    '{'{8'h00, 1'b0, 32'h0000_0000}, '0},
    '{'{8'h00, 1'b0, 32'h0000_0000}, '0},
    '{'{8'h00, 1'b1, 32'd20},         '{32'd11, 32'h0000_0000, 1'b0}}
  };

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // DUT ports
  logic      pkt_valid = 1'b0;
  logic      pkt_ready;
  pkt_beat_t pkt       = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_beat_t res;

  dual_table_duplicate_packet_filter_core i_dut (
    .clk,
    .rst,
    .pkt_valid,
    .pkt_ready,
    .pkt,
    .res_valid,
    .res_ready,
    .res
  );

  // Predictor state: the two tables plus the per-packet fold
  logic [31:0] left_tag    [TABLE_SIZE] = '{default: '0};
  logic [31:0] left_stamp  [TABLE_SIZE] = '{default: '0};
  logic [31:0] right_tag   [TABLE_SIZE] = '{default: '0};
  logic [31:0] right_stamp [TABLE_SIZE] = '{default: '0};
  logic [31:0] fold_acc     = '0;
  logic [23:0] gather_bytes = '0;
  logic [15:0] byte_count   = '0;
  logic        bytes_dropped = 1'b0;

  res_beat_t pending_results [$];
  res_beat_t typed_answers [$];
  int unsigned mismatches = 0;

  // Sender-to-taker hold requests, and the sender's own quiet flag
  int unsigned hold_requests = 0;
  bit          quiet_sender  = 1'b0;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] both;
    both = {v, v} << n;
    return both[63:32];
  endfunction

  // Age of one table entry for this hash; 0 means no match
  function automatic logic [31:0] match_age(input logic [31:0] s_hash,
                                            input logic [31:0] s_stamp,
                                            input logic [31:0] h,
                                            input logic [31:0] now);
    logic [31:0] age;
    if (s_hash != h || s_stamp == '0) return '0;
    age = now - s_stamp;
    return (age == '0) ? 32'd1 : age;
  endfunction

  // Fold one accepted byte; on the final byte look up, update, and report
  task automatic track_beat(input pkt_beat_t b, output bit done, output res_beat_t r);
    logic [31:0] seed_word;
    logic [31:0] h;
    logic [31:0] lage;
    logic [31:0] rage;
    int unsigned li;
    int unsigned ri;
    done = 1'b0;
    r    = '0;
    if (byte_count < MAX_BYTES) begin
      if (byte_count[1:0] == 2'd3) begin
        fold_acc     = rotl32(fold_acc, 5'd1) ^ {b.data_byte, gather_bytes};
        gather_bytes = '0;
      end else begin
        gather_bytes[8*byte_count[1:0] +: 8] = b.data_byte;
      end
      byte_count = byte_count + 16'd1;
    end else begin
      bytes_dropped = 1'b1;
    end
    if (b.last_byte) begin
      seed_word = {8'h00, gather_bytes} + {13'd0, byte_count, 3'b000};
      h = fold_acc ^ rotl32(seed_word, byte_count[6:2]);
      if (h[31]) h = -h;
      li   = {h[31:24], h[15:8]} % TABLE_SIZE;
      ri   = {h[23:16], h[7:0]} % TABLE_SIZE;
      lage = match_age(left_tag[li], left_stamp[li], h, b.current_time);
      rage = match_age(right_tag[ri], right_stamp[ri], h, b.current_time);
      left_tag[li]    = h;
      left_stamp[li]  = b.current_time;
      right_tag[ri]   = h;
      right_stamp[ri] = b.current_time;
      if (lage == '0) r.age_seconds = rage;
      else if (rage == '0) r.age_seconds = lage;
      else r.age_seconds = (lage > rage) ? rage : lage;
      r.packet_hash = h;
      r.too_long    = bytes_dropped;
      done          = 1'b1;
      fold_acc      = '0;
      gather_bytes  = '0;
      byte_count    = '0;
      bytes_dropped = 1'b0;
    end
  endtask

  // Predict on accepted bytes, compare accepted results in order
  always @(posedge clk) begin : observe
    bit        produced;
    res_beat_t predicted;
    res_beat_t want;
    if (!rst) begin
      if (pkt_valid && pkt_ready) begin
        track_beat(pkt, produced, predicted);
        if (produced) begin
          if (typed_answers.size() != 0) predicted = typed_answers.pop_front();
          pending_results.push_back(predicted);
        end
      end
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: age %0d hash %h too_long %b",
                     res.age_seconds, res.packet_hash, res.too_long);
        end else begin
          want = pending_results.pop_front();
          if (res.age_seconds !== want.age_seconds || res.packet_hash !== want.packet_hash ||
              res.too_long !== want.too_long) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want age %0d hash %h long %b, got age %0d hash %h long %b",
                       want.age_seconds, want.packet_hash, want.too_long,
                       res.age_seconds, res.packet_hash, res.too_long);
          end
        end
      end
    end
  end

  // Send one byte beat; entered and left at a falling edge
  task automatic send_beat(input pkt_beat_t b, input int unsigned gap);
    if (gap != 0) begin
      pkt_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pkt_valid <= 1'b1;
    pkt       <= b;
    do @(posedge clk); while (!pkt_ready);
    @(negedge clk);
  endtask

  logic [7:0] work_bytes [BUF_LEN];

  // Send a packet; bytes past the buffer are random, time rides the final byte
  task automatic send_packet(input int unsigned len, input logic [31:0] stamp,
                             input bit steady);
    pkt_beat_t   b;
    int unsigned gap;
    for (int unsigned i = 0; i < len; i++) begin
      b.data_byte    = (i < BUF_LEN) ? work_bytes[i] : 8'($urandom_range(0, 255));
      b.last_byte    = (i == len - 1);
      b.current_time = b.last_byte ? stamp : $urandom();
      gap = (steady || quiet_sender) ? 0 : $urandom_range(0, 7);
      send_beat(b, gap);
    end
  endtask

  // Result taker: random stalls, quiet stretches, one long hold-off
  initial begin : take_results
    int unsigned wait_cycles;
    int unsigned holds_served;
    bit          quiet_receiver;
    holds_served   = 0;
    quiet_receiver = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 30) == 0) quiet_receiver = !quiet_receiver;
      wait_cycles = quiet_receiver ? 0 : $urandom_range(0, 7);
      if (holds_served != hold_requests) begin
        wait_cycles = HOLD_CYCLES;
        holds_served++;
      end
      if (wait_cycles != 0) begin
        res_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      @(negedge clk);
    end
  end

  // Stimulus and end of run
  initial begin : drive_packets
    logic [7:0]  saved_bytes [SAVED_SLOTS][BUF_LEN];
    int unsigned saved_len [SAVED_SLOTS];
    int unsigned saved_count;
    int unsigned saved_next;
    int unsigned random_beats;
    int unsigned pick;
    int unsigned slot;
    int unsigned len;
    int unsigned drain_wait;
    bit          flood_done;
    logic [31:0] stamp_now;
    saved_count  = 0;
    saved_next   = 0;
    random_beats = 0;
    flood_done   = 1'b0;
    stamp_now    = 32'd100;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int unsigned n = 0; n < DIRECTED_ROWS; n++) begin
      if (DIRECTED[n].beat.last_byte) typed_answers.push_back(DIRECTED[n].want);
      send_beat(DIRECTED[n].beat, $urandom_range(0, 7));
    end

    // Random traffic: fresh packets, exact repeats, and near repeats
    while (random_beats < RANDOM_BEATS) begin
      case ($urandom_range(0, 15))
        0: stamp_now = $urandom();
        1: stamp_now = '0;
        2: stamp_now = stamp_now - $urandom_range(1, 500);
        default: stamp_now = stamp_now + $urandom_range(0, 3);
      endcase
      if ($urandom_range(0, 30) == 0) quiet_sender = !quiet_sender;
      if (!flood_done && random_beats >= FLOOD_START) begin
        // hold the result side off and flood short packets to fill the queue
        flood_done = 1'b1;
        hold_requests++;
        repeat (FLOOD_COUNT) begin
          work_bytes[0] = 8'($urandom_range(0, 255));
          send_packet(1, stamp_now, 1'b1);
          stamp_now = stamp_now + $urandom_range(0, 2);
        end
        random_beats += FLOOD_COUNT;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick >= 6 && saved_count != 0) begin
          slot = $urandom_range(0, saved_count - 1);
          len  = saved_len[slot];
          for (int unsigned i = 0; i < len; i++) work_bytes[i] = saved_bytes[slot][i];
          if (pick == 9)
            work_bytes[$urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, BUF_LEN) : $urandom_range(1, 12);
          for (int unsigned i = 0; i < len; i++) begin
            work_bytes[i]              = 8'($urandom_range(0, 255));
            saved_bytes[saved_next][i] = work_bytes[i];
          end
          saved_len[saved_next] = len;
          saved_next = (saved_next + 1) % SAVED_SLOTS;
          if (saved_count < SAVED_SLOTS) saved_count++;
        end
        send_packet(len, stamp_now, 1'b0);
        random_beats += len;
      end
    end

    pkt_valid <= 1'b0;
    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < 100000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (16) @(posedge clk);
    if (pending_results.size() != 0) mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
